FILE: rtl/rdsenc_pkg.sv
// ----------------------------------------------------------------------
// rdsenc_pkg
// Shared types, codes, constants and checkword functions of the RDS
// group bitstream encoder.
// ----------------------------------------------------------------------
package rdsenc_pkg;

    localparam int unsigned TEXT_WORDS     = 16;
    localparam int unsigned FREQ_PAIRS     = 16;
    localparam int unsigned BITS_PER_GROUP = 104;
    localparam int unsigned BLOCK_BITS     = 26;
    localparam int unsigned DATA_BITS      = 16;
    localparam int unsigned CHECK_BITS     = 10;

    localparam int unsigned MODE_W    = 2;
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned PAYLOAD_W = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned POS_W     = 7;

    localparam logic [10:0] GEN_POLY   = 11'h5B9;
    localparam logic [9:0]  CHECK_MASK = 10'h3FF;
    localparam logic [9:0]  OFS_A      = 10'h0FC;
    localparam logic [9:0]  OFS_B      = 10'h198;
    localparam logic [9:0]  OFS_C      = 10'h168;
    localparam logic [9:0]  OFS_D      = 10'h1B4;

    // group type code in block B bits 15..12, version A
    localparam logic [3:0] GTYPE_0A = 4'd0;
    localparam logic [3:0] GTYPE_2A = 4'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_TEXT = 2'd1,
        MODE_FREQ = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROGRAM_ID   = 3'd0,
        CFG_PROGRAM_TYPE = 3'd1,
        CFG_TRAFFIC      = 3'd2,
        CFG_DECODER      = 3'd3,
        CFG_STATION_NAME = 3'd4,
        CFG_TEXT_COUNT   = 3'd5,
        CFG_TEXT_AB      = 3'd6,
        CFG_FREQ_COUNT   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] program_id;
        logic [4:0]  program_type;
        logic [1:0]  traffic_bits;
        logic [4:0]  decoder_bits;
        logic [63:0] station_name;
        logic [4:0]  text_group_count;
        logic        text_ab_flag;
        logic [4:0]  freq_pair_count;
    } cfg_t;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
    } grp_words_t;

    typedef struct packed {
        logic                 text_we;
        logic                 freq_we;
        logic [SLOT_W-1:0]    idx;
        logic [PAYLOAD_W-1:0] data;
    } store_wr_t;

    // remainder of x^(10+pos) modulo the generator
    function automatic logic [CHECK_BITS-1:0] crc_column(input int unsigned pos);
        logic [BLOCK_BITS-1:0] r;
        r = BLOCK_BITS'(1) << (CHECK_BITS + pos);
        for (int i = BLOCK_BITS - 1; i >= int'(CHECK_BITS); i--)
        begin
            if (r[i])
            begin
                r = r ^ (BLOCK_BITS'(GEN_POLY) << (i - int'(CHECK_BITS)));
            end
        end
        return r[CHECK_BITS-1:0] & CHECK_MASK;
    endfunction

    function automatic logic [DATA_BITS-1:0][CHECK_BITS-1:0] crc_columns();
        logic [DATA_BITS-1:0][CHECK_BITS-1:0] cols;
        for (int i = 0; i < int'(DATA_BITS); i++)
        begin
            cols[i] = crc_column(i);
        end
        return cols;
    endfunction

    localparam logic [DATA_BITS-1:0][CHECK_BITS-1:0] CRC_COLS = crc_columns();

    // checkword is linear in the data bits: xor of one column per set bit
    function automatic logic [CHECK_BITS-1:0] check_word(input logic [DATA_BITS-1:0] data);
        logic [CHECK_BITS-1:0] cw;
        cw = '0;
        for (int i = 0; i < int'(DATA_BITS); i++)
        begin
            if (data[i])
            begin
                cw = cw ^ CRC_COLS[i];
            end
        end
        return cw;
    endfunction

endpackage

FILE: rtl/rdsenc_in_if.sv
// ----------------------------------------------------------------------
// rdsenc_in_if
// Command channel: bit ticks and store writes.
// ----------------------------------------------------------------------
interface rdsenc_in_if;

    logic                             valid;
    logic                             ready;
    logic [rdsenc_pkg::MODE_W-1:0]    mode;
    logic [rdsenc_pkg::SLOT_W-1:0]    slot_index;
    logic [rdsenc_pkg::PAYLOAD_W-1:0] payload;

    modport source
    (
        output valid,
        output mode,
        output slot_index,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  mode,
        input  slot_index,
        input  payload,
        output ready
    );

endinterface

FILE: rtl/rdsenc_out_if.sv
// ----------------------------------------------------------------------
// rdsenc_out_if
// Bit channel: one group bit per transfer with its line level.
// ----------------------------------------------------------------------
interface rdsenc_out_if;

    logic valid;
    logic ready;
    logic raw_bit;
    logic line_level;
    logic group_start;

    modport source
    (
        output valid,
        output raw_bit,
        output line_level,
        output group_start,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  raw_bit,
        input  line_level,
        input  group_start,
        output ready
    );

endinterface

FILE: rtl/rds_group_bitstream_encoder.sv
// ----------------------------------------------------------------------
// rds_group_bitstream_encoder
// Sends RDS 0A and 2A groups one bit per tick command, most significant
// bit first, with the differentially encoded line level alongside. Four
// 0A groups (name, DI, AF pair) alternate with four 2A groups (radiotext)
// once text_group_count is nonzero. Text and frequency writes go through
// the same command channel and return nothing. One command is taken every
// clock unless a tick finds the output register still holding an untaken
// bit; a tick's bit passes from the command register to the output
// register, where it is presented until taken. A new group, with its
// four checkwords, is built inside that command-to-output register step on
// the first tick after the previous group's 104th bit.
// ----------------------------------------------------------------------
module rds_group_bitstream_encoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    rdsenc_in_if.sink                           cmd,
    rdsenc_out_if.source                        tx,
    input  logic                                cfg_we,
    input  logic [rdsenc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [rdsenc_pkg::CFG_W-1:0]        cfg_wdata
);

    rdsenc_pkg::cfg_t cfg_reg;

    logic                             in_valid_reg;
    logic [rdsenc_pkg::MODE_W-1:0]    in_mode_reg;
    logic [rdsenc_pkg::SLOT_W-1:0]    in_slot_reg;
    logic [rdsenc_pkg::PAYLOAD_W-1:0] in_payload_reg;

    logic [rdsenc_pkg::BITS_PER_GROUP-1:0] group_reg;
    logic [rdsenc_pkg::POS_W-1:0]          bit_pos_reg;
    logic                                  diff_level_reg;

    logic out_valid_reg;
    logic raw_bit_reg;
    logic line_level_reg;
    logic group_start_reg;

    logic is_tick;
    logic out_free;
    logic advance;
    logic tick_go;
    logic build;
    logic bit_now;
    logic level_next;

    rdsenc_pkg::store_wr_t  st_wr;
    rdsenc_pkg::grp_words_t words;
    logic [rdsenc_pkg::SLOT_W-1:0]         text_addr;
    logic [rdsenc_pkg::SLOT_W-1:0]         freq_addr;
    logic [rdsenc_pkg::PAYLOAD_W-1:0]      text_word;
    logic [rdsenc_pkg::DATA_BITS-1:0]      freq_word;
    logic [rdsenc_pkg::BITS_PER_GROUP-1:0] new_group;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.program_id       <= '0;
            cfg_reg.program_type     <= '0;
            cfg_reg.traffic_bits     <= '0;
            cfg_reg.decoder_bits     <= 5'd24;
            cfg_reg.station_name     <= 64'h2020_2020_2020_2020;
            cfg_reg.text_group_count <= '0;
            cfg_reg.text_ab_flag     <= 1'b0;
            cfg_reg.freq_pair_count  <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                rdsenc_pkg::CFG_PROGRAM_ID:   cfg_reg.program_id       <= cfg_wdata[15:0];
                rdsenc_pkg::CFG_PROGRAM_TYPE: cfg_reg.program_type     <= cfg_wdata[4:0];
                rdsenc_pkg::CFG_TRAFFIC:      cfg_reg.traffic_bits     <= cfg_wdata[1:0];
                rdsenc_pkg::CFG_DECODER:      cfg_reg.decoder_bits     <= cfg_wdata[4:0];
                rdsenc_pkg::CFG_STATION_NAME: cfg_reg.station_name     <= cfg_wdata;
                rdsenc_pkg::CFG_TEXT_COUNT:   cfg_reg.text_group_count <= cfg_wdata[4:0];
                rdsenc_pkg::CFG_TEXT_AB:      cfg_reg.text_ab_flag     <= cfg_wdata[0];
                rdsenc_pkg::CFG_FREQ_COUNT:   cfg_reg.freq_pair_count  <= cfg_wdata[4:0];
            endcase
        end
    end

    // handshake: the command register moves on unless a tick finds the
    // output register still holding an untaken bit
    always_comb
    begin
        is_tick   = (in_mode_reg == rdsenc_pkg::MODE_TICK);
        out_free  = !out_valid_reg || tx.ready;
        advance   = in_valid_reg && (!is_tick || out_free);
        tick_go   = advance && is_tick;
        build     = tick_go && (bit_pos_reg >= rdsenc_pkg::POS_W'(rdsenc_pkg::BITS_PER_GROUP));
        bit_now   = build ? new_group[rdsenc_pkg::BITS_PER_GROUP-1]
                          : group_reg[rdsenc_pkg::BITS_PER_GROUP-1];
        level_next = diff_level_reg ^ bit_now;

        st_wr.idx     = in_slot_reg;
        st_wr.data    = in_payload_reg;
        st_wr.text_we = advance && (in_mode_reg == rdsenc_pkg::MODE_TEXT)
                     && ({1'b0, in_slot_reg} < 5'(rdsenc_pkg::TEXT_WORDS));
        st_wr.freq_we = advance && (in_mode_reg == rdsenc_pkg::MODE_FREQ)
                     && ({1'b0, in_slot_reg} < 5'(rdsenc_pkg::FREQ_PAIRS));
    end

    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_mode_reg    <= cmd.mode;
            in_slot_reg    <= cmd.slot_index;
            in_payload_reg <= cmd.payload;
        end
    end

    rdsenc_store u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (st_wr),
        .text_addr (text_addr),
        .freq_addr (freq_addr),
        .text_word (text_word),
        .freq_word (freq_word)
    );

    rdsenc_sched u_sched
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .build     (build),
        .text_word (text_word),
        .freq_word (freq_word),
        .text_addr (text_addr),
        .freq_addr (freq_addr),
        .words     (words)
    );

    rdsenc_group_build u_group_build
    (
        .words       (words),
        .coded_group (new_group)
    );

    // group shift register: the top bit is the next one to send
    always_ff @(posedge clk)
    begin
        if (build)
        begin
            group_reg <= {new_group[rdsenc_pkg::BITS_PER_GROUP-2:0], 1'b0};
        end
        else if (tick_go)
        begin
            group_reg <= {group_reg[rdsenc_pkg::BITS_PER_GROUP-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg    <= rdsenc_pkg::POS_W'(rdsenc_pkg::BITS_PER_GROUP);
            diff_level_reg <= 1'b0;
        end
        else if (tick_go)
        begin
            bit_pos_reg    <= build ? rdsenc_pkg::POS_W'(1) : bit_pos_reg + 7'd1;
            diff_level_reg <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            raw_bit_reg     <= bit_now;
            line_level_reg  <= level_next;
            group_start_reg <= build;
        end
    end

    assign tx.valid       = out_valid_reg;
    assign tx.raw_bit     = raw_bit_reg;
    assign tx.line_level  = line_level_reg;
    assign tx.group_start = group_start_reg;

    // bit counter never runs past one group
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg <= rdsenc_pkg::POS_W'(rdsenc_pkg::BITS_PER_GROUP))
        else $error("bit position beyond group length");

    // a group build restarts the count and flags the bit it sends
    a_build_start: assert property (@(posedge clk) disable iff (!rst_n)
        build |=> (bit_pos_reg == rdsenc_pkg::POS_W'(1)) && tx.valid && tx.group_start)
        else $error("group build did not restart bit position");

    // a held bit's level always matches the running differential level
    a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (line_level_reg == diff_level_reg))
        else $error("line level out of step with differential state");

    // a stalled command only ever waits behind a full output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> (out_valid_reg && !tx.ready && is_tick))
        else $error("command stalled without output back-pressure");

endmodule

FILE: rtl/rdsenc_group_build.sv
// ----------------------------------------------------------------------
// rdsenc_group_build
// Appends checkword and offset to each of the four block words and
// packs the 104-bit group, block A first.
// ----------------------------------------------------------------------
module rdsenc_group_build
(
    input  rdsenc_pkg::grp_words_t                    words,
    output logic [rdsenc_pkg::BITS_PER_GROUP-1:0]     coded_group
);

    logic [rdsenc_pkg::CHECK_BITS-1:0] cw_a;
    logic [rdsenc_pkg::CHECK_BITS-1:0] cw_b;
    logic [rdsenc_pkg::CHECK_BITS-1:0] cw_c;
    logic [rdsenc_pkg::CHECK_BITS-1:0] cw_d;

    always_comb
    begin
        cw_a = rdsenc_pkg::check_word(words.a) ^ rdsenc_pkg::OFS_A;
        cw_b = rdsenc_pkg::check_word(words.b) ^ rdsenc_pkg::OFS_B;
        cw_c = rdsenc_pkg::check_word(words.c) ^ rdsenc_pkg::OFS_C;
        cw_d = rdsenc_pkg::check_word(words.d) ^ rdsenc_pkg::OFS_D;
        coded_group = {words.a, cw_a, words.b, cw_b, words.c, cw_c, words.d, cw_d};
    end

endmodule

FILE: rtl/rdsenc_store.sv
// ----------------------------------------------------------------------
// rdsenc_store
// Radiotext word store and alternative-frequency pair store, one write
// port each and one read address each.
// ----------------------------------------------------------------------
module rdsenc_store
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rdsenc_pkg::store_wr_t               wr,
    input  logic [rdsenc_pkg::SLOT_W-1:0]       text_addr,
    input  logic [rdsenc_pkg::SLOT_W-1:0]       freq_addr,
    output logic [rdsenc_pkg::PAYLOAD_W-1:0]    text_word,
    output logic [rdsenc_pkg::DATA_BITS-1:0]    freq_word
);

    logic [rdsenc_pkg::PAYLOAD_W-1:0] text_mem_reg [rdsenc_pkg::TEXT_WORDS];
    logic [rdsenc_pkg::DATA_BITS-1:0] freq_mem_reg [rdsenc_pkg::FREQ_PAIRS];

    // text entries have no reset; the user must write each entry before it is read, the block does not enforce this
    always_ff @(posedge clk)
    begin
        if (wr.text_we)
        begin
            text_mem_reg[wr.idx] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(rdsenc_pkg::FREQ_PAIRS); i++)
            begin
                freq_mem_reg[i] <= '0;
            end
        end
        else if (wr.freq_we)
        begin
            freq_mem_reg[wr.idx] <= wr.data[rdsenc_pkg::DATA_BITS-1:0];
        end
    end

    assign text_word = text_mem_reg[text_addr];
    assign freq_word = freq_mem_reg[freq_addr];

endmodule

FILE: rtl/rdsenc_sched.sv
// ----------------------------------------------------------------------
// rdsenc_sched
// Group scheduler: picks 0A or 2A, keeps the name, text and frequency
// cursors and forms the four data words of the next group.
// ----------------------------------------------------------------------
module rdsenc_sched
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rdsenc_pkg::cfg_t                    cfg,
    input  logic                                build,
    input  logic [rdsenc_pkg::PAYLOAD_W-1:0]    text_word,
    input  logic [rdsenc_pkg::DATA_BITS-1:0]    freq_word,
    output logic [rdsenc_pkg::SLOT_W-1:0]       text_addr,
    output logic [rdsenc_pkg::SLOT_W-1:0]       freq_addr,
    output rdsenc_pkg::grp_words_t              words
);

    logic [1:0] name_seg_reg;
    logic [3:0] text_seg_reg;
    logic [2:0] slot_reg;
    logic [3:0] freq_cur_reg;

    logic [4:0]  text_cnt;
    logic [4:0]  freq_cnt;
    logic [3:0]  text_cur;
    logic [3:0]  freq_cur;
    logic [4:0]  text_inc;
    logic [4:0]  freq_inc;
    logic [3:0]  text_cur_next;
    logic [3:0]  freq_cur_next;
    logic        text_pick;
    logic [3:0]  di_bits;
    logic [3:0][15:0] name_words;
    logic [15:0] name_b;
    logic [15:0] text_b;

    always_comb
    begin
        text_cnt = (cfg.text_group_count > 5'(rdsenc_pkg::TEXT_WORDS))
                 ? 5'(rdsenc_pkg::TEXT_WORDS) : cfg.text_group_count;
        freq_cnt = (cfg.freq_pair_count > 5'(rdsenc_pkg::FREQ_PAIRS))
                 ? 5'(rdsenc_pkg::FREQ_PAIRS) : cfg.freq_pair_count;
        if (freq_cnt == 5'd0)
        begin
            freq_cnt = 5'd1;
        end

        // a cursor left beyond a shrunken count restarts at zero
        text_cur = ({1'b0, text_seg_reg} >= text_cnt) ? 4'd0 : text_seg_reg;
        freq_cur = ({1'b0, freq_cur_reg} >= freq_cnt) ? 4'd0 : freq_cur_reg;
        text_inc = {1'b0, text_cur} + 5'd1;
        freq_inc = {1'b0, freq_cur} + 5'd1;
        text_cur_next = (text_inc >= text_cnt) ? 4'd0 : text_inc[3:0];
        freq_cur_next = (freq_inc >= freq_cnt) ? 4'd0 : freq_inc[3:0];

        text_pick  = (text_cnt != 5'd0) && slot_reg[2];
        di_bits    = cfg.decoder_bits[3:0];
        name_words = cfg.station_name;

        name_b = {rdsenc_pkg::GTYPE_0A, 1'b0, cfg.traffic_bits[1], cfg.program_type,
                  cfg.traffic_bits[0], cfg.decoder_bits[4], di_bits[~name_seg_reg],
                  name_seg_reg};
        text_b = {rdsenc_pkg::GTYPE_2A, 1'b0, cfg.traffic_bits[1], cfg.program_type,
                  cfg.text_ab_flag, text_cur};

        words.a = cfg.program_id;
        if (text_pick)
        begin
            words.b = text_b;
            words.c = text_word[31:16];
            words.d = text_word[15:0];
        end
        else
        begin
            words.b = name_b;
            words.c = freq_word;
            words.d = name_words[~name_seg_reg];
        end
    end

    assign text_addr = text_cur;
    assign freq_addr = freq_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_seg_reg <= '0;
            text_seg_reg <= '0;
            slot_reg     <= '0;
            freq_cur_reg <= '0;
        end
        else if (build)
        begin
            slot_reg <= slot_reg + 3'd1;
            if (text_pick)
            begin
                text_seg_reg <= text_cur_next;
            end
            else
            begin
                name_seg_reg <= name_seg_reg + 2'd1;
                freq_cur_reg <= freq_cur_next;
            end
        end
    end

endmodule

FILE: dv/tb_rds_group_bitstream_encoder.sv
// ----------------------------------------------------------------------
// tb_rds_group_bitstream_encoder
// Self-checking bench for the RDS group encoder. Commands are driven from
// a pending queue, a behavioral copy of the encoder predicts each bit
// transfer, and the monitor checks the bit, level and group-start flags.
// ----------------------------------------------------------------------
module tb_rds_group_bitstream_encoder;

    import rdsenc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int SETTLE_TICKS = 6;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [SLOT_W-1:0]    slot;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_item_t;

    typedef struct packed {
        logic raw_bit;
        logic line_level;
        logic group_start;
    } tx_bit_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    rdsenc_in_if  cmd();
    rdsenc_out_if tx();

    rds_group_bitstream_encoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .tx        (tx),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    cmd_item_t pending_cmds[$];
    tx_bit_t   expected_bits[$];
    int        mismatch_count;
    int        src_idle_pct;
    int        snk_stall_pct;
    cmd_item_t drv_item;
    tx_bit_t   mon_bit;

    // encoder settings
    logic [15:0] pi_code;
    logic [4:0]  pty_code;
    logic [1:0]  tp_ta;
    logic [4:0]  ms_di;
    logic [63:0] ps_name;
    logic [4:0]  rt_groups;
    logic        rt_ab;
    logic [4:0]  af_pairs;

    // encoder state
    logic [25:0] group_words[4];
    int unsigned bit_pos;
    logic [1:0]  ps_seg;
    int unsigned rt_seg;
    logic [2:0]  sched_slot;
    int unsigned af_pos;
    logic        level;
    logic [31:0] rt_words[TEXT_WORDS];
    logic [15:0] af_words[FREQ_PAIRS];

    always #5 clk = ~clk;

    function automatic logic [25:0] coded_block(input logic [15:0] data,
                                                input logic [9:0] offset);
        logic [25:0] rem;
        rem = {data, 10'b0};
        for (int i = 25; i >= 10; i--)
        begin
            if (rem[i])
            begin
                rem = rem ^ (26'(GEN_POLY) << (i - 10));
            end
        end
        return {data, rem[9:0] ^ offset};
    endfunction

    // apply one accepted command; a tick yields one expected bit
    function automatic void encode_command(input cmd_item_t it);
        int unsigned rt_cnt;
        int unsigned af_cnt;
        logic [15:0] blk_b;
        logic [15:0] blk_c;
        logic [15:0] blk_d;
        logic [31:0] word;
        tx_bit_t     res;
        if (it.mode == MODE_TEXT)
        begin
            rt_words[it.slot] = it.payload;
        end
        else if (it.mode == MODE_FREQ)
        begin
            af_words[it.slot] = it.payload[15:0];
        end
        else if (it.mode == MODE_TICK)
        begin
            res.group_start = (bit_pos >= BITS_PER_GROUP);
            if (res.group_start)
            begin
                rt_cnt = (rt_groups > TEXT_WORDS) ? TEXT_WORDS : rt_groups;
                if (rt_cnt > 0 && sched_slot[2])
                begin
                    if (rt_seg >= rt_cnt)
                        rt_seg = 0;
                    word  = rt_words[rt_seg];
                    blk_b = {GTYPE_2A, 1'b0, tp_ta[1], pty_code, rt_ab, 4'(rt_seg)};
                    blk_c = word[31:16];
                    blk_d = word[15:0];
                    rt_seg++;
                    if (rt_seg >= rt_cnt)
                        rt_seg = 0;
                end
                else
                begin
                    af_cnt = (af_pairs > FREQ_PAIRS) ? FREQ_PAIRS : af_pairs;
                    if (af_cnt == 0)
                        af_cnt = 1;
                    if (af_pos >= af_cnt)
                        af_pos = 0;
                    blk_b = {5'd0, tp_ta[1], pty_code, tp_ta[0], ms_di[4],
                             ms_di[3 - ps_seg], ps_seg};
                    blk_c = af_words[af_pos];
                    blk_d = ps_name[(3 - ps_seg) * 16 +: 16];
                    af_pos++;
                    if (af_pos >= af_cnt)
                        af_pos = 0;
                    ps_seg = ps_seg + 2'd1;
                end
                sched_slot     = sched_slot + 3'd1;
                group_words[0] = coded_block(pi_code, OFS_A);
                group_words[1] = coded_block(blk_b, OFS_B);
                group_words[2] = coded_block(blk_c, OFS_C);
                group_words[3] = coded_block(blk_d, OFS_D);
                bit_pos        = 0;
            end
            res.raw_bit    = group_words[bit_pos / BLOCK_BITS][25 - bit_pos % BLOCK_BITS];
            bit_pos++;
            level          = level ^ res.raw_bit;
            res.line_level = level;
            expected_bits.push_back(res);
        end
    endfunction

    task automatic write_cfg(input cfg_idx_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PROGRAM_ID:   pi_code   = val[15:0];
            CFG_PROGRAM_TYPE: pty_code  = val[4:0];
            CFG_TRAFFIC:      tp_ta     = val[1:0];
            CFG_DECODER:      ms_di     = val[4:0];
            CFG_STATION_NAME: ps_name   = val;
            CFG_TEXT_COUNT:   rt_groups = val[4:0];
            CFG_TEXT_AB:      rt_ab     = val[0];
            CFG_FREQ_COUNT:   af_pairs  = val[4:0];
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                             input logic [PAYLOAD_W-1:0] payload);
        cmd_item_t it;
        it.mode    = mode;
        it.slot    = slot;
        it.payload = payload;
        pending_cmds.push_back(it);
    endtask

    // every command transferred, every bit seen, then let writes settle
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd.valid || expected_bits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                drv_item.mode    = cmd.mode;
                drv_item.slot    = cmd.slot_index;
                drv_item.payload = cmd.payload;
                encode_command(drv_item);
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    drv_item = pending_cmds.pop_front();
                    cmd.valid      <= 1'b1;
                    cmd.mode       <= drv_item.mode;
                    cmd.slot_index <= drv_item.slot;
                    cmd.payload    <= drv_item.payload;
                end
                else
                begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            tx.ready <= 1'b0;
        else
            tx.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // bit monitor
    always @(posedge clk)
    begin
        if (rst_n && tx.valid && tx.ready)
        begin
            if (expected_bits.size() == 0)
            begin
                $error("bit transfer with nothing expected");
                mismatch_count++;
            end
            else
            begin
                mon_bit = expected_bits.pop_front();
                if (tx.raw_bit !== mon_bit.raw_bit)
                begin
                    $error("raw_bit: expected %0b, actual %0b", mon_bit.raw_bit, tx.raw_bit);
                    mismatch_count++;
                end
                if (tx.line_level !== mon_bit.line_level)
                begin
                    $error("line_level: expected %0b, actual %0b",
                           mon_bit.line_level, tx.line_level);
                    mismatch_count++;
                end
                if (tx.group_start !== mon_bit.group_start)
                begin
                    $error("group_start: expected %0b, actual %0b",
                           mon_bit.group_start, tx.group_start);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int sel;
        logic [4:0] rt_val;
        logic [4:0] af_val;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_PROGRAM_ID;
        cfg_wdata      = '0;
        cmd.valid      = 1'b0;
        cmd.mode       = MODE_TICK;
        cmd.slot_index = '0;
        cmd.payload    = '0;
        tx.ready       = 1'b0;
        mismatch_count = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;

        pi_code   = '0;
        pty_code  = '0;
        tp_ta     = '0;
        ms_di     = 5'd24;
        ps_name   = 64'h2020202020202020;
        rt_groups = '0;
        rt_ab     = 1'b0;
        af_pairs  = 5'd1;
        bit_pos    = BITS_PER_GROUP;
        ps_seg     = '0;
        rt_seg     = 0;
        sched_slot = '0;
        af_pos     = 0;
        level      = 1'b0;
        for (int i = 0; i < TEXT_WORDS; i++)
            rt_words[i] = '0;
        for (int i = 0; i < FREQ_PAIRS; i++)
            af_words[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
                default: begin src_idle_pct = 16; snk_stall_pct = 16; end
            endcase

            // first phase runs on the reset settings
            if (p == 1)
            begin
                write_cfg(CFG_PROGRAM_ID, 64'hFFFF);
                write_cfg(CFG_PROGRAM_TYPE, 64'd31);
                write_cfg(CFG_TRAFFIC, 64'd3);
                write_cfg(CFG_DECODER, 64'd31);
                write_cfg(CFG_STATION_NAME, 64'hFFFF_FFFF_FFFF_FFFF);
                write_cfg(CFG_TEXT_COUNT, 64'd16);
                write_cfg(CFG_TEXT_AB, 64'd1);
                write_cfg(CFG_FREQ_COUNT, 64'd16);
            end
            else if (p == 2)
            begin
                // text count drops under the cursor, zero pair count acts as one
                write_cfg(CFG_PROGRAM_ID, 64'h0);
                write_cfg(CFG_PROGRAM_TYPE, 64'd0);
                write_cfg(CFG_TRAFFIC, 64'd0);
                write_cfg(CFG_DECODER, 64'd0);
                write_cfg(CFG_STATION_NAME, 64'h0);
                write_cfg(CFG_TEXT_COUNT, 64'd1);
                write_cfg(CFG_TEXT_AB, 64'd0);
                write_cfg(CFG_FREQ_COUNT, 64'd0);
            end
            else if (p > 2)
            begin
                // counts past the store size saturate
                rt_val = (p == 3) ? 5'd31 : 5'($urandom_range(0, 31));
                af_val = (p == 3) ? 5'd31 : 5'($urandom_range(0, 31));
                write_cfg(CFG_PROGRAM_ID, 64'($urandom_range(0, 65535)));
                write_cfg(CFG_PROGRAM_TYPE, 64'($urandom_range(0, 31)));
                write_cfg(CFG_TRAFFIC, 64'($urandom_range(0, 3)));
                write_cfg(CFG_DECODER, 64'($urandom_range(0, 31)));
                write_cfg(CFG_STATION_NAME, {$urandom, $urandom});
                write_cfg(CFG_TEXT_COUNT, 64'(rt_val));
                write_cfg(CFG_TEXT_AB, 64'($urandom_range(0, 1)));
                write_cfg(CFG_FREQ_COUNT, 64'(af_val));
            end
            if (p > 0)
            begin
                @(posedge clk);
                cfg_we <= 1'b0;
            end

            if (p == 0)
            begin
                // fill the whole text store before any text group can read it
                queue_cmd(MODE_TEXT, 4'd0, 32'hFFFF_FFFF);
                queue_cmd(MODE_TEXT, 4'd1, 32'h0);
                for (int s = 2; s < TEXT_WORDS; s++)
                    queue_cmd(MODE_TEXT, 4'(s), $urandom);
                queue_cmd(MODE_TICK, 4'd15, 32'hFFFF_FFFF);
                // upper half of a frequency payload is dropped
                queue_cmd(MODE_FREQ, 4'd0, 32'hFFFF_FFFF);
                queue_cmd(MODE_FREQ, 4'd15, $urandom);
                queue_cmd(MODE_UNUSED, 4'd15, 32'hFFFF_FFFF);
                queue_cmd(MODE_TICK, 4'd0, 32'h0);
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 84)
                    queue_cmd(MODE_TICK, 4'($urandom_range(0, 15)), $urandom);
                else if (sel < 92)
                    queue_cmd(MODE_TEXT, 4'($urandom_range(0, 15)), $urandom);
                else if (sel < 98)
                    queue_cmd(MODE_FREQ, 4'($urandom_range(0, 15)), $urandom);
                else
                    queue_cmd(MODE_UNUSED, 4'($urandom_range(0, 15)), $urandom);
            end

            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_bits.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // about 1450 commands in all; this timeout is far past their run time
    initial
    begin
        #3000000;
        $display("FAIL");
        $finish;
    end

endmodule
